[design/four_lane_checksum64_unit_macros.svh]
// Assertion macros for the checksum unit.
`ifndef FOUR_LANE_CHECKSUM64_UNIT_MACROS_SVH
`define FOUR_LANE_CHECKSUM64_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check outside reset
`define FLC64_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define FLC64_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FLC64_ASSERT(lbl, prop, msg)

`define FLC64_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[design/flc64_pkg.sv]
package flc64_pkg;

  localparam logic [63:0] SEED_A = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] SEED_B = 64'hd1b5_4a32_d192_ed03;
  localparam logic [63:0] SEED_C = 64'h94d0_49bb_1331_11eb;
  localparam logic [63:0] SEED_D = 64'h243f_6a88_85a3_08d3;
  localparam logic [63:0] MIX_K1 = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] MIX_K2 = 64'hc4ce_b9fe_1a85_ec53;

  localparam int unsigned ROT_B_IN  = 17;
  localparam int unsigned ROT_D_IN  = 31;
  localparam int unsigned ROT_B_MIX = 13;
  localparam int unsigned ROT_C_MIX = 29;
  localparam int unsigned ROT_D_MIX = 47;
  localparam int unsigned FMIX_SHR  = 33;

  localparam logic [3:0] BYTES_PER_WORD = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GRP,
    S_FOLD,
    S_FOLDB,
    S_TAILC,
    S_TAILD,
    S_MIX,
    S_MUL,
    S_SHX,
    S_DONE
  } state_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage

[design/four_lane_checksum64_unit.sv]
// channel | signals                              | direction
// --------+--------------------------------------+----------
// in      | in_valid, in_ready, data_word,       | input
//         | byte_count, last                     |
// out     | out_valid, out_ready, checksum       | output
//
// A non-last word is taken while idle, plus the group step if it ends a group
// of four. A last word runs the group finish if it ends a group, fold steps per
// leftover word, tail steps for a partial tail, lane mix, and two 64-bit
// multiplies of four steps on one shared 32x32 multiplier and a 64-bit adder.
// Reset clears the lanes to their seeds; no clearing pass is needed.
// A result waiting on out_ready holds the unit in its final step only.
`include "four_lane_checksum64_unit_macros.svh"

module four_lane_checksum64_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] checksum
);
  import flc64_pkg::*;

  state_t      state;
  state_t      state_next;

  logic [63:0] lane_a;
  logic [63:0] lane_b;
  logic [63:0] lane_c;
  logic [63:0] lane_d;
  logic [63:0] pend [3];
  logic [1:0]  pend_cnt;
  logic [63:0] total_bytes;
  logic [1:0]  fold_idx;
  logic        fin;
  logic        has_tail;
  logic [63:0] tail;
  logic [63:0] x;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [1:0]  mstep;
  logic        kphase;

  logic        in_fire;
  logic        done_go;
  logic [3:0]  eff_cnt;
  logic [3:0]  add_cnt;
  logic        is_full;
  logic        group;
  logic [63:0] tail_mask;
  logic [63:0] add_x;
  logic [63:0] add_y;
  logic [63:0] sum;
  logic [63:0] mix_k;
  logic [31:0] mul_x;
  logic [31:0] mul_k;
  logic [63:0] mul_p;
  logic [63:0] mixed;

  assign in_fire   = in_valid && in_ready;
  assign done_go   = (state == S_DONE) && (!out_valid || out_ready);
  assign eff_cnt   = (byte_count > BYTES_PER_WORD) ? BYTES_PER_WORD : byte_count;
  assign add_cnt   = last ? eff_cnt : BYTES_PER_WORD;
  assign is_full   = !last || (eff_cnt == BYTES_PER_WORD);
  assign group     = is_full && (pend_cnt == 2'd3);
  assign tail_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {eff_cnt, 3'b000});

  assign mix_k = kphase ? MIX_K2 : MIX_K1;
  assign mul_x = (mstep == 2'd1) ? x[63:32] : x[31:0];
  assign mul_k = (mstep == 2'd2) ? mix_k[63:32] : mix_k[31:0];
  assign mul_p = mul_x * mul_k;

  assign mixed = lane_a ^ rotl64(lane_b, ROT_B_MIX) ^ rotl64(lane_c, ROT_C_MIX)
               ^ rotl64(lane_d, ROT_D_MIX) ^ total_bytes;

  always_comb begin
    unique case (state)
      S_FOLD: begin
        add_x = lane_a;
        add_y = pend[fold_idx];
      end
      S_FOLDB: begin
        add_x = lane_b;
        add_y = lane_a;
      end
      S_TAILC: begin
        add_x = lane_c;
        add_y = tail;
      end
      S_TAILD: begin
        add_x = lane_d;
        add_y = lane_c;
      end
      S_MUL: begin
        add_x = acc;
        add_y = {prod[31:0], 32'b0};
      end
      default: begin
        add_x = '0;
        add_y = '0;
      end
    endcase
    sum = add_x + add_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (group) begin
            state_next = S_GRP;
          end else if (last) begin
            state_next = S_FOLD;
          end
        end
      end
      S_GRP: begin
        state_next = fin ? S_FOLD : S_IDLE;
      end
      S_FOLD: begin
        if (fold_idx < pend_cnt) begin
          state_next = S_FOLDB;
        end else begin
          state_next = has_tail ? S_TAILC : S_MIX;
        end
      end
      S_FOLDB: state_next = S_FOLD;
      S_TAILC: state_next = S_TAILD;
      S_TAILD: state_next = S_MIX;
      S_MIX:   state_next = S_MUL;
      S_MUL: begin
        if (mstep == 2'd3) begin
          state_next = S_SHX;
        end
      end
      S_SHX: begin
        state_next = kphase ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (done_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_a      <= SEED_A;
      lane_b      <= SEED_B;
      lane_c      <= SEED_C;
      lane_d      <= SEED_D;
      pend_cnt    <= '0;
      total_bytes <= '0;
      fold_idx    <= '0;
      fin         <= 1'b0;
      has_tail    <= 1'b0;
      mstep       <= '0;
      kphase      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (done_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            total_bytes <= total_bytes + {60'b0, add_cnt};
            fin         <= last;
            has_tail    <= last && (eff_cnt != 4'd0) && (eff_cnt != BYTES_PER_WORD);
            tail        <= data_word & tail_mask;
            fold_idx    <= '0;
            if (is_full) begin
              if (group) begin
                lane_a   <= lane_a + pend[0];
                lane_b   <= lane_b ^ rotl64(pend[1], ROT_B_IN);
                lane_c   <= lane_c + pend[2];
                lane_d   <= lane_d ^ rotl64(data_word, ROT_D_IN);
                pend_cnt <= '0;
              end else begin
                pend[pend_cnt] <= data_word;
                pend_cnt       <= pend_cnt + 2'd1;
              end
            end
          end
        end
        S_GRP: begin
          lane_b <= lane_b + lane_a;
          lane_d <= lane_d + lane_c;
        end
        S_FOLD: begin
          if (fold_idx < pend_cnt) begin
            lane_a <= sum;
          end
        end
        S_FOLDB: begin
          lane_b   <= sum;
          fold_idx <= fold_idx + 2'd1;
        end
        S_TAILC: lane_c <= sum;
        S_TAILD: lane_d <= sum;
        S_MIX: begin
          x      <= mixed ^ (mixed >> FMIX_SHR);
          mstep  <= '0;
          kphase <= 1'b0;
        end
        S_MUL: begin
          mstep <= mstep + 2'd1;
          prod  <= mul_p;
          if (mstep == 2'd1) begin
            acc <= prod;
          end else if (mstep != 2'd0) begin
            acc <= sum;
          end
        end
        S_SHX: begin
          x      <= acc ^ (acc >> FMIX_SHR);
          kphase <= 1'b1;
        end
        S_DONE: begin
          if (done_go) begin
            checksum    <= x;
            lane_a      <= SEED_A;
            lane_b      <= SEED_B;
            lane_c      <= SEED_C;
            lane_d      <= SEED_D;
            pend_cnt    <= '0;
            total_bytes <= '0;
            fold_idx    <= '0;
            fin         <= 1'b0;
            kphase      <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `FLC64_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !out_valid), "reset not idle")
  `FLC64_ASSERT(a_group_clears, group && in_fire |=> state == S_GRP && pend_cnt == '0, "no group")
  `FLC64_ASSERT(a_fold_bound, state == S_FOLD || state == S_FOLDB |-> fold_idx <= pend_cnt, "fold overrun")
  `FLC64_ASSERT(a_mstep_mul, (mstep != 2'd0) |-> (state == S_MUL), "multiply step outside multiply")
  `FLC64_ASSERT(a_done_clears, done_go |=> out_valid && total_bytes == '0, "not cleared")

endmodule
